// ----- src/bpthp_pkg.sv -----
`default_nettype none
package bpthp_pkg;

  localparam int unsigned TABLE_SIZE = 1024;
  localparam int unsigned ADDR_W     = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W      = ADDR_W + 1;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned KEY_W      = 4 * WORD_W;
  localparam int unsigned ENTRY_W    = 2 * KEY_W;
  localparam int unsigned IN_W       = 272;
  localparam int unsigned OUT_W      = 272;
  localparam logic [WORD_W-1:0] GOLDEN = 32'h9e37_79b9;
  localparam logic [1:0] HASH_LAST   = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_READ,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- src/block_page_table_hash_probe_core.sv -----
`default_nettype none
// Hash-probed page table: 1024 slots of a 128-bit key and a 128-bit value.
// Channels: in_* carries one request (load, query, update or read); out_* returns
// exactly one result per request. No configuration port.
//
// Load writes the entry at index and echoes it; read fetches the entry at index
// in a read state. Query/update fold the key into a 32-bit hash with one shared
// add/shift/xor unit, then walk the probe order base - i*i (mod 1024) through the
// single table read port, one slot per cycle, compare in the cycle after the read.
// A miss issues all 1024 probes. Update rewrites the value on the hit cycle.
//
// in_tready is high only while idle: one request at a time. The result sits in an
// output register, so the next request is taken while a result waits; if the
// receiver still stalls when the next result is ready, the block holds in its
// final state until the output register frees up.
// Reset clears the control state only. Table contents are undefined until
// loaded; every slot must be loaded before queries or updates.
module block_page_table_hash_probe_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // command[1:0], index[11:2], key_x..key_w[139:12], value_x..value_w[267:140], pad
  input  wire logic [bpthp_pkg::IN_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // found[0], slot[10:1], out_key_x..out_key_w[138:11],
  // out_value_x..out_value_w[266:139], pad
  output logic [bpthp_pkg::OUT_W-1:0]        out_tdata
);

  localparam int unsigned AW = bpthp_pkg::ADDR_W;
  localparam int unsigned CW = bpthp_pkg::CNT_W;
  localparam int unsigned KW = bpthp_pkg::KEY_W;
  localparam int unsigned EW = bpthp_pkg::ENTRY_W;
  localparam int unsigned WW = bpthp_pkg::WORD_W;
  localparam int unsigned SW = bpthp_pkg::SLOT_W;
  localparam int unsigned DW = 1 + SW + EW;

  // table: {value[127:0], key[127:0]}, words x in the low bits
  logic [EW-1:0] mem [bpthp_pkg::TABLE_SIZE];
  logic [EW-1:0] rd_data_r;

  bpthp_pkg::state_t state_r, state_nxt;
  bpthp_pkg::cmd_t   cmd_r, in_cmd;

  logic [AW-1:0] idx_r, in_idx;
  logic [KW-1:0] key_r, val_r, in_key, in_val;

  // hash unit
  logic [1:0]    step_r;
  logic [WW-1:0] v_r, hash_word, hash_nxt;

  // probe walk
  logic [AW-1:0] base_r, sq_r, odd_r, probe_addr, rd_slot_r;
  logic [CW-1:0] cnt_r;
  logic          rd_vld_r;
  logic          issue_done, hit, miss, issuing;

  // result bookkeeping
  logic          found_r;
  logic [AW-1:0] slot_r;
  logic          out_tvalid_r, out_free;
  logic [bpthp_pkg::OUT_W-1:0] out_tdata_r;
  logic [DW-1:0] res_data;

  // memory port controls
  logic          rd_en, wr_en, in_acc;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  assign in_cmd = bpthp_pkg::cmd_t'(in_tdata[1:0]);
  assign in_idx = in_tdata[2 +: AW];
  assign in_key = in_tdata[12 +: KW];
  assign in_val = in_tdata[12 + KW +: KW];
  assign in_acc = in_tvalid && in_tready;

  // one fold step: v ^= word + golden + (v << 6) + (v >> 2)
  always_comb begin
    case (step_r)
      2'd0:    hash_word = key_r[WW +: WW];
      2'd1:    hash_word = key_r[2*WW +: WW];
      default: hash_word = key_r[3*WW +: WW];
    endcase
    hash_nxt = v_r ^ (hash_word + bpthp_pkg::GOLDEN + (v_r << 6) + (v_r >> 2));
  end

  assign probe_addr = base_r - sq_r;
  assign issue_done = (cnt_r == CW'(bpthp_pkg::TABLE_SIZE));
  assign hit        = (state_r == bpthp_pkg::ST_PROBE) && rd_vld_r &&
                      (rd_data_r[KW-1:0] == key_r);
  assign miss       = (state_r == bpthp_pkg::ST_PROBE) && !rd_vld_r && issue_done;
  assign out_free   = !out_tvalid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpthp_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          case (in_cmd)
            bpthp_pkg::CMD_LOAD:  state_nxt = bpthp_pkg::ST_DONE;
            bpthp_pkg::CMD_READ:  state_nxt = bpthp_pkg::ST_READ;
            default:              state_nxt = bpthp_pkg::ST_HASH;
          endcase
        end
      end
      bpthp_pkg::ST_HASH: begin
        if (step_r == bpthp_pkg::HASH_LAST) state_nxt = bpthp_pkg::ST_PROBE;
      end
      bpthp_pkg::ST_PROBE: begin
        if (hit || miss) state_nxt = bpthp_pkg::ST_DONE;
      end
      bpthp_pkg::ST_READ: state_nxt = bpthp_pkg::ST_DONE;
      bpthp_pkg::ST_DONE: begin
        if (out_free) state_nxt = bpthp_pkg::ST_IDLE;
      end
      default: state_nxt = bpthp_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = (state_r == bpthp_pkg::ST_IDLE);
    issuing   = (state_r == bpthp_pkg::ST_PROBE) && !issue_done && !hit;
    rd_en     = issuing || (state_r == bpthp_pkg::ST_READ);
    rd_addr   = (state_r == bpthp_pkg::ST_READ) ? idx_r : probe_addr;
    wr_en     = (in_acc && (in_cmd == bpthp_pkg::CMD_LOAD)) ||
                (hit && (cmd_r == bpthp_pkg::CMD_UPDATE));
    wr_addr   = (state_r == bpthp_pkg::ST_IDLE) ? in_idx : rd_slot_r;
    wr_data   = (state_r == bpthp_pkg::ST_IDLE) ? {in_val, in_key}
                                                : {val_r, rd_data_r[KW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bpthp_pkg::ST_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issuing;
    end
  end

  // request capture, hash and probe datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_cmd;
      idx_r  <= in_idx;
      key_r  <= in_key;
      val_r  <= in_val;
      v_r    <= in_key[WW-1:0];
      step_r <= 2'd0;
      found_r <= 1'b1;
      slot_r <= in_idx;
    end
    if (state_r == bpthp_pkg::ST_HASH) begin
      v_r    <= hash_nxt;
      step_r <= step_r + 2'd1;
      base_r <= hash_nxt[AW-1:0];
      sq_r   <= '0;
      odd_r  <= AW'(1);
      cnt_r  <= '0;
    end
    if (issuing) begin
      // (i+1)^2 = i^2 + (2i + 1)
      sq_r      <= sq_r + odd_r;
      odd_r     <= odd_r + AW'(2);
      cnt_r     <= cnt_r + CW'(1);
      rd_slot_r <= probe_addr;
    end
    if (hit) begin
      found_r <= 1'b1;
      slot_r  <= rd_slot_r;
    end else if (miss) begin
      found_r <= 1'b0;
    end
  end

  // result assembly
  always_comb begin
    if (!found_r) begin
      res_data = '0;
    end else begin
      case (cmd_r)
        bpthp_pkg::CMD_LOAD:   res_data = {val_r, key_r, SW'(slot_r), 1'b1};
        bpthp_pkg::CMD_UPDATE: res_data = {val_r, rd_data_r[KW-1:0], SW'(slot_r), 1'b1};
        default:               res_data = {rd_data_r, SW'(slot_r), 1'b1};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == bpthp_pkg::ST_DONE) && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == bpthp_pkg::ST_DONE) && out_free) begin
      out_tdata_r <= bpthp_pkg::OUT_W'(res_data);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // probe walk never issues past the table size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bpthp_pkg::ST_PROBE) |-> (cnt_r <= CW'(bpthp_pkg::TABLE_SIZE)))
    else $error("probe count past table size");

  // single-port table: no read and write in the same cycle
  a_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("table read and write collide");

  // leaving the final state always presents a result
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == bpthp_pkg::ST_DONE) && out_free) |=> out_tvalid)
    else $error("result not presented");

  // hash runs exactly three fold steps before probing
  a_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bpthp_pkg::ST_PROBE && $past(state_r) == bpthp_pkg::ST_HASH) |->
    ($past(step_r) == bpthp_pkg::HASH_LAST))
    else $error("hash step count wrong");

endmodule
`default_nettype wire
